FILE: rtl/core/bst_pkg.sv
// ---------------------------------------------------------------------------
// Byte stream tokenizer package
// Word types for both channels, the per-byte result bundle and token codes.
// ---------------------------------------------------------------------------
package bst_pkg;

  // width of every position and line field on the result channel
  localparam int FIELD_BITS = 24;
  // most results one source byte can cause
  localparam int MAX_RESULTS = 3;

  // token kinds
  localparam logic [4:0] KIND_LPAREN  = 5'd0;
  localparam logic [4:0] KIND_RPAREN  = 5'd1;
  localparam logic [4:0] KIND_LBRACE  = 5'd2;
  localparam logic [4:0] KIND_RBRACE  = 5'd3;
  localparam logic [4:0] KIND_LBRACK  = 5'd4;
  localparam logic [4:0] KIND_RBRACK  = 5'd5;
  localparam logic [4:0] KIND_COLON   = 5'd6;
  localparam logic [4:0] KIND_SEMI    = 5'd7;
  localparam logic [4:0] KIND_EQEQ    = 5'd8;
  localparam logic [4:0] KIND_ASSIGN  = 5'd9;
  localparam logic [4:0] KIND_GE      = 5'd10;
  localparam logic [4:0] KIND_GT      = 5'd11;
  localparam logic [4:0] KIND_LE      = 5'd12;
  localparam logic [4:0] KIND_LT      = 5'd13;
  localparam logic [4:0] KIND_NE      = 5'd14;
  localparam logic [4:0] KIND_NOT     = 5'd15;
  localparam logic [4:0] KIND_STAR    = 5'd16;
  localparam logic [4:0] KIND_STRING  = 5'd17;
  localparam logic [4:0] KIND_END     = 5'd18;
  localparam logic [4:0] KIND_ERROR   = 5'd19;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN    = 2'd1;
  localparam logic [1:0] ERR_NL_STRING  = 2'd2;
  localparam logic [1:0] ERR_UNTERM     = 2'd3;

  // input word
  typedef struct packed {
    logic [7:0] source_byte;
    logic       final_byte;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [4:0]            token_kind;
    logic [1:0]            error_code;
    logic [FIELD_BITS-1:0] token_start;
    logic [FIELD_BITS-1:0] span_begin;
    logic [FIELD_BITS-1:0] span_end;
    logic [FIELD_BITS-1:0] line_index;
    logic [FIELD_BITS-1:0] line_begin;
    logic                  run_last;
  } out_word_t;

  // one result as it sits in the queue
  typedef struct packed {
    logic [4:0]            token_kind;
    logic [1:0]            error_code;
    logic [FIELD_BITS-1:0] token_start;
    logic [FIELD_BITS-1:0] span_begin;
    logic [FIELD_BITS-1:0] span_end;
    logic [FIELD_BITS-1:0] line_index;
    logic [FIELD_BITS-1:0] line_begin;
  } res_t;

  // all results of one source byte, count is 1..3 when queued
  typedef struct packed {
    logic [1:0]                 count;
    res_t [MAX_RESULTS-1:0]     slot;
  } bundle_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

endpackage

FILE: rtl/core/bst_scan.sv
// ---------------------------------------------------------------------------
// Byte stream tokenizer front end
// Classifies one source byte per cycle while the queue has room and builds its bundle of results.
// ---------------------------------------------------------------------------
module bst_scan #(
  parameter int POSITION_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  bst_pkg::in_word_t   src_word,
  input  bst_pkg::q_flags_t   q_flags,
  output logic                push,
  output bst_pkg::bundle_t    bundle
);

  localparam int FB = bst_pkg::FIELD_BITS;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    M_NORMAL,
    M_PEND_EQ,
    M_PEND_GT,
    M_PEND_LT,
    M_PEND_NOT,
    M_COMMENT,
    M_STRING,
    M_HALTED
  } mode_t;

  // scanner state
  mode_t                    mode, mode_next;
  logic                     quote_dbl, quote_dbl_next;
  logic                     prior_bs, prior_bs_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [POSITION_BITS-1:0] pend_start, pend_start_next;
  logic [POSITION_BITS-1:0] line_cnt, line_cnt_next;
  logic [POSITION_BITS-1:0] line_start, line_start_next;

  // byte decode for normal scanning
  logic       dec_hit;
  logic [4:0] dec_kind;
  logic [1:0] dec_code;
  logic       dec_pend;
  mode_t      dec_pend_mode;
  logic       dec_comment;
  logic       dec_quote;
  logic       dec_nl;

  // candidate results in emission order
  logic             va, vb, vc, vd;
  bst_pkg::res_t    ra, rb, rc, rd;
  logic [1:0]       n;
  logic             accept;
  logic [7:0]       b;
  logic [7:0]       quote_ch;
  logic [POSITION_BITS-1:0] pos_inc;

  function automatic bst_pkg::res_t mk_res(
    input logic [4:0]               kind,
    input logic [1:0]               code,
    input logic [POSITION_BITS-1:0] start,
    input logic [POSITION_BITS-1:0] sb,
    input logic [POSITION_BITS-1:0] se,
    input logic [POSITION_BITS-1:0] li,
    input logic [POSITION_BITS-1:0] lb
  );
    bst_pkg::res_t r;
    r.token_kind  = kind;
    r.error_code  = code;
    r.token_start = FB'(start);
    r.span_begin  = FB'(sb);
    r.span_end    = FB'(se);
    r.line_index  = FB'(li);
    r.line_begin  = FB'(lb);
    return r;
  endfunction

  // kind of a held operator, two-character form when eq
  function automatic logic [4:0] held_kind(input mode_t m, input logic eq);
    logic [4:0] k;
    case (m)
      M_PEND_EQ:  k = eq ? bst_pkg::KIND_EQEQ : bst_pkg::KIND_ASSIGN;
      M_PEND_GT:  k = eq ? bst_pkg::KIND_GE   : bst_pkg::KIND_GT;
      M_PEND_LT:  k = eq ? bst_pkg::KIND_LE   : bst_pkg::KIND_LT;
      M_PEND_NOT: k = eq ? bst_pkg::KIND_NE   : bst_pkg::KIND_NOT;
      default:    k = bst_pkg::KIND_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic is_pend(input mode_t m);
    return (m == M_PEND_EQ) || (m == M_PEND_GT) || (m == M_PEND_LT) ||
           (m == M_PEND_NOT);
  endfunction

  assign b         = src_word.source_byte;
  assign src_stall = q_flags.full;
  assign accept    = src_valid & ~q_flags.full;
  assign pos_inc   = pos + POSITION_BITS'(1);
  assign quote_ch  = quote_dbl ? CH_DQUOTE : CH_SQUOTE;

  // decode of a byte seen in normal mode
  always_comb begin
    dec_hit       = 1'b1;
    dec_kind      = bst_pkg::KIND_ERROR;
    dec_code      = bst_pkg::ERR_NONE;
    dec_pend      = 1'b0;
    dec_pend_mode = M_NORMAL;
    dec_comment   = 1'b0;
    dec_quote     = 1'b0;
    dec_nl        = 1'b0;
    case (b)
      CH_LPAREN: dec_kind = bst_pkg::KIND_LPAREN;
      CH_RPAREN: dec_kind = bst_pkg::KIND_RPAREN;
      CH_LBRACE: dec_kind = bst_pkg::KIND_LBRACE;
      CH_RBRACE: dec_kind = bst_pkg::KIND_RBRACE;
      CH_LBRACK: dec_kind = bst_pkg::KIND_LBRACK;
      CH_RBRACK: dec_kind = bst_pkg::KIND_RBRACK;
      CH_COLON:  dec_kind = bst_pkg::KIND_COLON;
      CH_SEMI:   dec_kind = bst_pkg::KIND_SEMI;
      CH_STAR:   dec_kind = bst_pkg::KIND_STAR;
      CH_EQ: begin
        dec_hit = 1'b0; dec_pend = 1'b1; dec_pend_mode = M_PEND_EQ;
      end
      CH_GT: begin
        dec_hit = 1'b0; dec_pend = 1'b1; dec_pend_mode = M_PEND_GT;
      end
      CH_LT: begin
        dec_hit = 1'b0; dec_pend = 1'b1; dec_pend_mode = M_PEND_LT;
      end
      CH_BANG: begin
        dec_hit = 1'b0; dec_pend = 1'b1; dec_pend_mode = M_PEND_NOT;
      end
      CH_SPACE, CH_TAB, CH_CR: dec_hit = 1'b0;
      CH_NL: begin
        dec_hit = 1'b0; dec_nl = 1'b1;
      end
      CH_HASH: begin
        dec_hit = 1'b0; dec_comment = 1'b1;
      end
      CH_SQUOTE, CH_DQUOTE: begin
        dec_hit = 1'b0; dec_quote = 1'b1;
      end
      default: dec_code = bst_pkg::ERR_UNKNOWN;
    endcase
  end

  // next state and results for this byte
  always_comb begin
    mode_next       = mode;
    quote_dbl_next  = quote_dbl;
    prior_bs_next   = prior_bs;
    pos_next        = pos_inc;
    pend_start_next = pend_start;
    line_cnt_next   = line_cnt;
    line_start_next = line_start;
    va = 1'b0; vb = 1'b0; vc = 1'b0; vd = 1'b0;
    ra = '0; rb = '0; rc = '0; rd = '0;

    // normal-scan outcome, used by normal mode and after a held operator
    if (mode == M_NORMAL || (is_pend(mode) && b != CH_EQ)) begin
      mode_next = M_NORMAL;
      if (dec_pend) begin
        mode_next       = dec_pend_mode;
        pend_start_next = pos;
      end
      if (dec_comment) mode_next = M_COMMENT;
      if (dec_quote) begin
        mode_next       = M_STRING;
        quote_dbl_next  = (b == CH_DQUOTE);
        prior_bs_next   = 1'b0;
        pend_start_next = pos;
      end
      if (dec_nl) begin
        line_cnt_next   = line_cnt + POSITION_BITS'(1);
        line_start_next = pos_inc;
      end
    end

    case (mode)
      M_HALTED: begin
        pos_next = pos;
      end
      M_PEND_EQ, M_PEND_GT, M_PEND_LT, M_PEND_NOT: begin
        va = 1'b1;
        ra = mk_res(held_kind(mode, b == CH_EQ), bst_pkg::ERR_NONE, pend_start,
                    '0, '0, line_cnt, line_start);
        if (b == CH_EQ) begin
          mode_next = M_NORMAL;
        end else begin
          vb = dec_hit;
          rb = mk_res(dec_kind, dec_code, pos, '0, '0, line_cnt, line_start);
        end
      end
      M_COMMENT: begin
        if (b == CH_NL) begin
          line_cnt_next   = line_cnt + POSITION_BITS'(1);
          line_start_next = pos_inc;
          mode_next       = M_NORMAL;
        end
      end
      M_STRING: begin
        if (b == quote_ch && !prior_bs) begin
          va = 1'b1;
          ra = mk_res(bst_pkg::KIND_STRING, bst_pkg::ERR_NONE, pend_start,
                      pend_start + POSITION_BITS'(1), pos, line_cnt, line_start);
          mode_next     = M_NORMAL;
          prior_bs_next = 1'b0;
        end else if (b == CH_NL) begin
          va = 1'b1;
          ra = mk_res(bst_pkg::KIND_ERROR, bst_pkg::ERR_NL_STRING, pend_start,
                      '0, '0, line_cnt, line_start);
          mode_next = M_HALTED;
        end else begin
          prior_bs_next = (b == CH_BSLASH);
        end
      end
      default: begin
        va = dec_hit;
        ra = mk_res(dec_kind, dec_code, pos, '0, '0, line_cnt, line_start);
      end
    endcase

    // end of source: flush a held operator or an open string, then end
    if (src_word.final_byte) begin
      if (mode != M_HALTED && mode_next != M_HALTED) begin
        if (is_pend(mode_next)) begin
          vc = 1'b1;
          rc = mk_res(held_kind(mode_next, 1'b0), bst_pkg::ERR_NONE,
                      pend_start_next, '0, '0, line_cnt_next, line_start_next);
        end else if (mode_next == M_STRING) begin
          vc = 1'b1;
          rc = mk_res(bst_pkg::KIND_ERROR, bst_pkg::ERR_UNTERM, pend_start_next,
                      '0, '0, line_cnt_next, line_start_next);
        end
        vd = 1'b1;
        rd = mk_res(bst_pkg::KIND_END, bst_pkg::ERR_NONE, pos_inc, '0, '0,
                    line_cnt_next, line_start_next);
      end
      mode_next       = M_NORMAL;
      quote_dbl_next  = 1'b0;
      prior_bs_next   = 1'b0;
      pos_next        = '0;
      pend_start_next = '0;
      line_cnt_next   = '0;
      line_start_next = '0;
    end
  end

  // pack the valid results into the bundle, in order
  always_comb begin
    bundle = '0;
    n      = 2'd0;
    if (va) begin bundle.slot[n] = ra; n = 2'(n + 2'd1); end
    if (vb) begin bundle.slot[n] = rb; n = 2'(n + 2'd1); end
    if (vc) begin bundle.slot[n] = rc; n = 2'(n + 2'd1); end
    if (vd) begin bundle.slot[n] = rd; n = 2'(n + 2'd1); end
    bundle.count = n;
  end

  assign push = accept && (n != 2'd0);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_NORMAL;
      quote_dbl  <= 1'b0;
      prior_bs   <= 1'b0;
      pos        <= '0;
      pend_start <= '0;
      line_cnt   <= '0;
      line_start <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      quote_dbl  <= quote_dbl_next;
      prior_bs   <= prior_bs_next;
      pos        <= pos_next;
      pend_start <= pend_start_next;
      line_cnt   <= line_cnt_next;
      line_start <= line_start_next;
    end
  end

endmodule

FILE: rtl/core/bst_queue.sv
// ---------------------------------------------------------------------------
// Byte stream tokenizer bundle queue
// Small register FIFO of result bundles between the front and back ends.
// ---------------------------------------------------------------------------
module bst_queue #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bst_pkg::bundle_t   push_data,
  input  logic               pop,
  output bst_pkg::bundle_t   head,
  output bst_pkg::q_flags_t  flags
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bst_pkg::bundle_t  entries [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     fill;
  logic              do_push;
  logic              do_pop;

  assign flags.full  = (fill == CW'(QUEUE_DEPTH));
  assign flags.empty = (fill == '0);
  assign do_push     = push & ~flags.full;
  assign do_pop      = pop & ~flags.empty;
  assign head        = entries[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr + PW'(1));
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr + PW'(1));
      end
      if (do_push && !do_pop) fill <= CW'(fill + CW'(1));
      else if (do_pop && !do_push) fill <= CW'(fill - CW'(1));
    end
  end

endmodule

FILE: rtl/core/bst_emit.sv
// ---------------------------------------------------------------------------
// Byte stream tokenizer back end
// Takes bundles from the queue and sends their results one word per cycle while tok_stall is low.
// ---------------------------------------------------------------------------
module bst_emit (
  input  logic               clk,
  input  logic               rst,
  input  bst_pkg::bundle_t   head,
  input  bst_pkg::q_flags_t  q_flags,
  output logic               pop,
  output logic               tok_valid,
  input  logic               tok_stall,
  output bst_pkg::out_word_t tok_word
);

  bst_pkg::bundle_t cur;
  logic             cur_valid;
  logic [1:0]       idx;
  logic             last;
  logic             done;
  bst_pkg::res_t    sel;

  assign last  = (idx == 2'(cur.count - 2'd1));
  assign done  = cur_valid & ~tok_stall & last;
  // load a bundle when nothing is held or the held one just finished
  assign pop   = ~q_flags.empty & (~cur_valid | done);

  assign sel       = cur.slot[idx];
  assign tok_valid = cur_valid;

  // output word from the held bundle
  always_comb begin
    tok_word.token_kind  = sel.token_kind;
    tok_word.error_code  = sel.error_code;
    tok_word.token_start = sel.token_start;
    tok_word.span_begin  = sel.span_begin;
    tok_word.span_end    = sel.span_end;
    tok_word.line_index  = sel.line_index;
    tok_word.line_begin  = sel.line_begin;
    tok_word.run_last    = last;
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  // walk through the results of the held bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (done) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (cur_valid && !tok_stall) begin
      idx <= 2'(idx + 2'd1);
    end
  end

endmodule

FILE: rtl/core/byte_stream_tokenizer.sv
// ---------------------------------------------------------------------------
// Byte stream tokenizer
// One-pass lexer over a byte stream with one byte of operator lookahead.
// ---------------------------------------------------------------------------
//  channel  direction  handshake             word
//  src      in         src_valid/src_stall   in_word_t  (source_byte, final_byte)
//  tok      out        tok_valid/tok_stall   out_word_t (one token or error)
//
//  The front end takes one byte per cycle while the bundle queue has room.
//  Each byte makes 0 to 3 results; the back end sends one result per cycle
//  while tok is not stalled.
//  Reset clears the scanner state, the queue pointers and the output valid.
//  A stall on tok fills the queue of QUEUE_DEPTH bundles, then stalls src.
// ---------------------------------------------------------------------------
module byte_stream_tokenizer #(
  parameter int POSITION_BITS = 24,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  bst_pkg::in_word_t  src_word,
  output logic               tok_valid,
  input  logic               tok_stall,
  output bst_pkg::out_word_t tok_word
);

  logic              push;
  logic              pop;
  bst_pkg::bundle_t  push_data;
  bst_pkg::bundle_t  head;
  bst_pkg::q_flags_t q_flags;

  // front end: scanner
  bst_scan #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .q_flags   (q_flags),
    .push      (push),
    .bundle    (push_data)
  );

  // bundle queue
  bst_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .flags     (q_flags)
  );

  // back end: result serializer
  bst_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_flags   (q_flags),
    .pop       (pop),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_word  (tok_word)
  );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte stream tokenizer testbench
// Streams source bytes into the lexer and keeps a byte-level model of its
// scanner. Every token word is checked against the oldest predicted word.
// Directed sources cover punctuation, operators, blanks, comments, strings
// and errors. A long random run of well-formed text with some noise follows.
// Both sides idle at random, except for a stretch of the random run.
// ---------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 200000;

  // character codes the scanner treats specially
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;

  // byte pools for random text, indexed a byte at a time
  localparam logic [8*9-1:0] PUNCT_SET = "(){}[]:;*";
  localparam logic [8*4-1:0] OPER_SET  = "=<>!";
  localparam logic [8*4-1:0] BLANK_SET = {CH_SPACE, CH_TAB, CH_CR, CH_LF};

  typedef enum logic [3:0] {
    SCAN_NORMAL,
    SCAN_HELD_EQ,
    SCAN_HELD_GT,
    SCAN_HELD_LT,
    SCAN_HELD_NOT,
    SCAN_COMMENT,
    SCAN_STRING,
    SCAN_HALTED
  } scan_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               src_valid;
  logic               src_stall;
  bst_pkg::in_word_t  src_word;
  logic               tok_valid;
  logic               tok_stall = 1'b0;
  bst_pkg::out_word_t tok_word;

  byte_stream_tokenizer uut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_word  (tok_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scanner model state
  scan_t       scan_state = SCAN_NORMAL;
  logic        quote_dq = 1'b0;
  logic        after_backslash = 1'b0;
  logic [23:0] cur_pos = '0;
  logic [23:0] held_start = '0;
  logic [23:0] line_no = '0;
  logic [23:0] line_head = '0;

  bst_pkg::out_word_t step_tokens[$];
  bst_pkg::out_word_t token_queue[$];
  int        errors = 0;
  int        bytes_sent = 0;
  bit        gaps_on = 1'b1;

  // ---------------------------------------------------------------------
  // Scanner model
  // ---------------------------------------------------------------------
  function automatic void clear_scan();
    scan_state = SCAN_NORMAL;
    quote_dq = 1'b0;
    after_backslash = 1'b0;
    cur_pos = '0;
    held_start = '0;
    line_no = '0;
    line_head = '0;
  endfunction

  function automatic void add_token(input logic [4:0] kind, input logic [1:0] code,
                                    input logic [23:0] start, input logic [23:0] sb,
                                    input logic [23:0] se);
    bst_pkg::out_word_t w;
    w.token_kind  = kind;
    w.error_code  = code;
    w.token_start = start;
    w.span_begin  = sb;
    w.span_end    = se;
    w.line_index  = line_no;
    w.line_begin  = line_head;
    w.run_last    = 1'b0;
    step_tokens.insert(step_tokens.size(), w);
  endfunction

  function automatic bit is_held(input scan_t m);
    return m == SCAN_HELD_EQ || m == SCAN_HELD_GT || m == SCAN_HELD_LT ||
           m == SCAN_HELD_NOT;
  endfunction

  // one- or two-character kind of a held operator
  function automatic logic [4:0] held_kind(input scan_t m, input bit eq);
    case (m)
      SCAN_HELD_EQ: return eq ? bst_pkg::KIND_EQEQ : bst_pkg::KIND_ASSIGN;
      SCAN_HELD_GT: return eq ? bst_pkg::KIND_GE : bst_pkg::KIND_GT;
      SCAN_HELD_LT: return eq ? bst_pkg::KIND_LE : bst_pkg::KIND_LT;
      default:      return eq ? bst_pkg::KIND_NE : bst_pkg::KIND_NOT;
    endcase
  endfunction

  function automatic void hold_op(input scan_t m, input logic [23:0] p);
    scan_state = m;
    held_start = p;
  endfunction

  // byte seen in normal scanning
  function automatic void scan_plain(input logic [7:0] b, input logic [23:0] p);
    case (b)
      "(": add_token(bst_pkg::KIND_LPAREN, bst_pkg::ERR_NONE, p, '0, '0);
      ")": add_token(bst_pkg::KIND_RPAREN, bst_pkg::ERR_NONE, p, '0, '0);
      "{": add_token(bst_pkg::KIND_LBRACE, bst_pkg::ERR_NONE, p, '0, '0);
      "}": add_token(bst_pkg::KIND_RBRACE, bst_pkg::ERR_NONE, p, '0, '0);
      "[": add_token(bst_pkg::KIND_LBRACK, bst_pkg::ERR_NONE, p, '0, '0);
      "]": add_token(bst_pkg::KIND_RBRACK, bst_pkg::ERR_NONE, p, '0, '0);
      ":": add_token(bst_pkg::KIND_COLON, bst_pkg::ERR_NONE, p, '0, '0);
      ";": add_token(bst_pkg::KIND_SEMI, bst_pkg::ERR_NONE, p, '0, '0);
      "*": add_token(bst_pkg::KIND_STAR, bst_pkg::ERR_NONE, p, '0, '0);
      CH_EQ:   hold_op(SCAN_HELD_EQ, p);
      CH_GT:   hold_op(SCAN_HELD_GT, p);
      CH_LT:   hold_op(SCAN_HELD_LT, p);
      CH_BANG: hold_op(SCAN_HELD_NOT, p);
      CH_SPACE, CH_TAB, CH_CR: ;
      CH_LF: begin
        line_no = line_no + 1'b1;
        line_head = p + 1'b1;
      end
      CH_HASH: scan_state = SCAN_COMMENT;
      CH_SQUOTE, CH_DQUOTE: begin
        scan_state = SCAN_STRING;
        quote_dq = (b == CH_DQUOTE);
        after_backslash = 1'b0;
        held_start = p;
      end
      default: add_token(bst_pkg::KIND_ERROR, bst_pkg::ERR_UNKNOWN, p, '0, '0);
    endcase
  endfunction

  // predict every token word caused by one source byte
  function automatic void predict_byte(input logic [7:0] b, input logic fin);
    logic [23:0]        p;
    scan_t              m;
    logic [7:0]         q;
    bst_pkg::out_word_t w;
    p = cur_pos;
    m = scan_state;
    step_tokens.delete();
    if (m == SCAN_HALTED) begin
      if (fin) clear_scan();
      return;
    end
    if (is_held(m)) begin
      scan_state = SCAN_NORMAL;
      add_token(held_kind(m, b == CH_EQ), bst_pkg::ERR_NONE, held_start, '0, '0);
      if (b != CH_EQ) scan_plain(b, p);
    end else if (m == SCAN_COMMENT) begin
      if (b == CH_LF) begin
        line_no = line_no + 1'b1;
        line_head = p + 1'b1;
        scan_state = SCAN_NORMAL;
      end
    end else if (m == SCAN_STRING) begin
      q = quote_dq ? CH_DQUOTE : CH_SQUOTE;
      if (b == q && !after_backslash) begin
        add_token(bst_pkg::KIND_STRING, bst_pkg::ERR_NONE, held_start,
                  held_start + 1'b1, p);
        scan_state = SCAN_NORMAL;
        after_backslash = 1'b0;
      end else if (b == CH_LF) begin
        add_token(bst_pkg::KIND_ERROR, bst_pkg::ERR_NL_STRING, held_start, '0, '0);
        scan_state = SCAN_HALTED;
      end else begin
        after_backslash = (b == CH_BSLASH);
      end
    end else begin
      scan_state = SCAN_NORMAL;
      scan_plain(b, p);
    end
    cur_pos = p + 1'b1;

    // end of source: flush a held operator or open string, then end token
    if (fin) begin
      if (scan_state != SCAN_HALTED) begin
        if (is_held(scan_state))
          add_token(held_kind(scan_state, 1'b0), bst_pkg::ERR_NONE, held_start,
                    '0, '0);
        else if (scan_state == SCAN_STRING)
          add_token(bst_pkg::KIND_ERROR, bst_pkg::ERR_UNTERM, held_start, '0, '0);
        add_token(bst_pkg::KIND_END, bst_pkg::ERR_NONE, cur_pos, '0, '0);
      end
      clear_scan();
    end

    if (step_tokens.size() > 0) begin
      w = step_tokens.pop_back();
      w.run_last = 1'b1;
      step_tokens.insert(step_tokens.size(), w);
    end
    foreach (step_tokens[i]) token_queue.insert(token_queue.size(), step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------
  // entered and left just after a falling edge
  task automatic send_byte(input logic [7:0] b, input logic fin);
    bst_pkg::in_word_t w;
    while (gaps_on && $urandom_range(99) < 25) begin
      src_valid <= 1'b0;
      @(negedge clk);
    end
    predict_byte(b, fin);
    w.source_byte = b;
    w.final_byte = fin;
    src_valid <= 1'b1;
    src_word <= w;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit fin_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], fin_last && i == s.len() - 1);
  endtask

  // random text byte, now and then ending the source
  task automatic send_src(input logic [7:0] b);
    send_byte(b, $urandom_range(99) < 3);
  endtask

  task automatic wait_drained();
    src_valid <= 1'b0;
    @(negedge clk);
    while (token_queue.size() != 0) @(negedge clk);
  endtask

  // one lexeme with random content (a string may hold a newline), or a noise byte
  task automatic send_fragment();
    int         sel;
    int         len;
    logic [7:0] q;
    sel = $urandom_range(99);
    if (sel < 25) begin
      send_src(PUNCT_SET[8*$urandom_range(8) +: 8]);
    end else if (sel < 45) begin
      send_src(OPER_SET[8*$urandom_range(3) +: 8]);
      if ($urandom_range(1)) send_src(CH_EQ);
    end else if (sel < 57) begin
      send_src(BLANK_SET[8*$urandom_range(3) +: 8]);
    end else if (sel < 65) begin
      send_src(CH_HASH);
      len = $urandom_range(5);
      repeat (len) send_src(8'($urandom_range(8'h7E, 8'h20)));
      send_src(CH_LF);
    end else if (sel < 85) begin
      q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
      send_src(q);
      len = $urandom_range(6);
      repeat (len) begin
        if ($urandom_range(4) == 0) begin
          send_src(CH_BSLASH);
          send_src(q);
        end else begin
          send_src(8'($urandom_range(8'h7E, 8'h20)));
        end
      end
      if ($urandom_range(9) == 0) send_src(CH_LF);
      send_src(q);
    end else begin
      send_src(8'($urandom_range(255)));
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // every punctuation token, unknown bytes at both ends of the byte range
  task automatic test_punctuation();
    send_byte(8'h00, 1'b0);
    send_text("(){}[]:;*", 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // two-char operators, held operators broken by another byte, one held at the end
  task automatic test_operators();
    send_text("==>=<=!==><!", 1'b1);
  endtask

  // blanks, line counting, a closed comment and one still open at the end
  task automatic test_blanks_comments();
    send_text(" \t", 1'b0);
    send_byte(CH_CR, 1'b0);
    send_text("\n#x\n#", 1'b1);
  endtask

  // escaped quote, newline in a string and the halt, unterminated string
  task automatic test_strings();
    send_text("'a\\'b'\"\n", 1'b0);
    send_byte("(", 1'b1);
    send_text("'u", 1'b1);
  endtask

  task automatic test_random_text();
    int  base;
    bit  paused;
    base = bytes_sent;
    paused = 1'b0;
    while (bytes_sent < base + 185) begin
      gaps_on = !(bytes_sent >= base + 60 && bytes_sent < base + 120);
      if (!paused && bytes_sent >= base + 95) begin
        wait_drained();
        paused = 1'b1;
      end
      send_fragment();
    end
    gaps_on = 1'b1;
    send_byte(CH_SPACE, 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Token side
  // ---------------------------------------------------------------------
  always @(negedge clk) tok_stall <= gaps_on && ($urandom_range(99) < 25);

  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_word
    bst_pkg::out_word_t want;
    if (!rst && tok_valid && !tok_stall) begin
      if (token_queue.size() == 0) begin
        $display("%0t: unexpected token word, expected none actual kind %0d",
                 $time, tok_word.token_kind);
        errors++;
      end else begin
        want = token_queue.pop_front();
        check_field("token_kind", 24'(want.token_kind), 24'(tok_word.token_kind));
        check_field("error_code", 24'(want.error_code), 24'(tok_word.error_code));
        check_field("token_start", want.token_start, tok_word.token_start);
        check_field("span_begin", want.span_begin, tok_word.span_begin);
        check_field("span_end", want.span_end, tok_word.span_end);
        check_field("line_index", want.line_index, tok_word.line_index);
        check_field("line_begin", want.line_begin, tok_word.line_begin);
        check_field("run_last", 24'(want.run_last), 24'(tok_word.run_last));
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("byte_stream_tokenizer test failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    src_valid = 1'b0;
    src_word = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_punctuation();
    test_operators();
    test_blanks_comments();
    test_strings();
    test_random_text();
    wait_drained();
    repeat (40) @(negedge clk);
    if (errors == 0 && token_queue.size() == 0) begin
      $display("byte_stream_tokenizer test passed");
    end else begin
      $display("byte_stream_tokenizer test failed");
    end
    $finish;
  end

endmodule

FILE: byte_stream_tokenizer.f
rtl/core/bst_pkg.sv
rtl/core/bst_scan.sv
rtl/core/bst_queue.sv
rtl/core/bst_emit.sv
rtl/core/byte_stream_tokenizer.sv
tb/sv/testbench.sv
